/* rtl/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the integer literal scanner.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT = 64;

   // radix codes as they appear on the result
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_BIN = 2'd2;
   localparam logic [1:0] RADIX_OCT = 2'd3;

   // suffix codes as they appear on the result
   localparam logic [2:0] SFX_NONE = 3'd0;
   localparam logic [2:0] SFX_U    = 3'd1;
   localparam logic [2:0] SFX_UL   = 3'd2;
   localparam logic [2:0] SFX_ULL  = 3'd3;
   localparam logic [2:0] SFX_L    = 3'd4;
   localparam logic [2:0] SFX_LL   = 3'd5;

   typedef struct packed {
      logic [7:0] char_code;
      logic       starts_literal;
   } ils_char_type;

   typedef struct packed {
      logic [1:0] radix_kind;
      logic [2:0] suffix_kind;
      logic       digit_range_error;
      logic       overflow_error;
      logic       no_digits_error;
      logic       final_char_consumed;
   } ils_flags_type;

endpackage

/* rtl/ils_req_if.sv */
// ----------------------------------------------------------------------------
// ils_req_if
// Character channel: one source character per transaction.
// ----------------------------------------------------------------------------
interface ils_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       starts_literal;

   modport source (output valid, output char_code, output starts_literal, input ready);
   modport sink   (input valid, input char_code, input starts_literal, output ready);
endinterface

/* rtl/ils_rsp_if.sv */
// ----------------------------------------------------------------------------
// ils_rsp_if
// Token channel: one scanned integer literal per transaction.
// ----------------------------------------------------------------------------
interface ils_rsp_if #(
   parameter int unsigned VALUE_BITS = 64
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] literal_value;
   logic [1:0]            radix_kind;
   logic [2:0]            suffix_kind;
   logic                  digit_range_error;
   logic                  overflow_error;
   logic                  no_digits_error;
   logic                  final_char_consumed;

   modport source (
      output valid, output literal_value, output radix_kind, output suffix_kind,
      output digit_range_error, output overflow_error, output no_digits_error,
      output final_char_consumed, input ready
   );
   modport sink (
      input valid, input literal_value, input radix_kind, input suffix_kind,
      input digit_range_error, input overflow_error, input no_digits_error,
      input final_char_consumed, output ready
   );
endinterface

/* rtl/integer_literal_scanner.sv */
// ----------------------------------------------------------------------------
// integer_literal_scanner
// Scans integer literals one character per transaction and returns one
// token transaction per finished literal.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                       handshake
//  req_chan   in   char_code, starts_literal                     valid/ready
//  rsp_chan   out  literal_value, radix_kind, suffix_kind,       valid/ready
//                  digit/overflow/no-digits flags, consumed flag
//
//  one character per cycle sustained while no held result stalls it; a token
//  reaches the token channel through the input register, then the result register
//  the scan step is one shift-add and compare on the value between the two
//  registers, so the accumulate path sets the clock
//  synchronous reset returns the scanner to idle with both registers empty
//  a held result only stalls a character that would end another token;
//  characters that produce no token keep flowing past it
// ----------------------------------------------------------------------------
module integer_literal_scanner #(
   parameter int unsigned VALUE_BITS = ils_pkg::VALUE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);
   import ils_pkg::*;

   // character held in the input register
   logic                  item_valid;
   ils_char_type          item;

   // scan step outputs
   logic                  emit;
   logic [VALUE_BITS-1:0] value;
   ils_flags_type         flags;

   // pipeline control
   logic                  slot_free;
   logic                  fire;

   // the held character moves on unless it ends a token and the result
   // register is still occupied
   assign fire = item_valid && (!emit || slot_free);

   ils_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   ils_scan_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scan_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .item  (item),
      .emit  (emit),
      .value (value),
      .flags (flags)
   );

   ils_result_reg #(
      .VALUE_BITS (VALUE_BITS)
   ) u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .value     (value),
      .flags     (flags),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   // a new token only shows up after a step that ended a literal
   a_rsp_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(fire && emit))
      else $error("token transaction appeared without a finishing step");

   // overflow always zeroes the reported value
   a_ovf_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overflow_error) |-> (rsp_chan.literal_value == '0))
      else $error("overflowed literal reported a nonzero value");

   // only a completed two-letter l suffix consumes the ending character
   a_consumed_suffix : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.final_char_consumed) |->
         (rsp_chan.suffix_kind == SFX_ULL || rsp_chan.suffix_kind == SFX_LL))
      else $error("ending character consumed without ull or ll suffix");

   // a stalled step must keep the held character in the input register
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (item_valid && emit && !slot_free) |=> (item_valid && $stable(item)))
      else $error("held character lost while the result register was busy");
`endif

endmodule

/* rtl/ils_input_reg.sv */
// ----------------------------------------------------------------------------
// ils_input_reg
// Input register holding one character until the scan step takes it.
// ----------------------------------------------------------------------------
module ils_input_reg (
   input  logic                clock,
   input  logic                reset,
   ils_req_if.sink             req_chan,
   input  logic                advance,
   output logic                item_valid,
   output ils_pkg::ils_char_type item
);
   import ils_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   ils_char_type item_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.char_code      <= req_chan.char_code;
         item_ff.starts_literal <= req_chan.starts_literal;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/ils_scan_core.sv */
// ----------------------------------------------------------------------------
// ils_scan_core
// Scanner state and the single-pass step for one character.
// ----------------------------------------------------------------------------
module ils_scan_core #(
   parameter int unsigned VALUE_BITS = ils_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ils_pkg::ils_char_type item,
   output logic                  emit,
   output logic [VALUE_BITS-1:0] value,
   output ils_pkg::ils_flags_type flags
);
   import ils_pkg::*;

   localparam int unsigned PW = VALUE_BITS + 4;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_ZERO      = 3'd1;
   localparam logic [2:0] PH_DIGITS    = 3'd2;
   localparam logic [2:0] PH_OVF_SKIP  = 3'd3;
   localparam logic [2:0] PH_SUF_U     = 3'd4;
   localparam logic [2:0] PH_SUF_UL    = 3'd5;
   localparam logic [2:0] PH_SUF_L     = 3'd6;
   localparam logic [2:0] PH_SUF_START = 3'd7;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_UP_B  = 8'h42;
   localparam logic [7:0] CH_LO_U  = 8'h75;
   localparam logic [7:0] CH_UP_U  = 8'h55;
   localparam logic [7:0] CH_LO_L  = 8'h6C;
   localparam logic [7:0] CH_UP_L  = 8'h4C;

   logic [2:0]            phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            radix_ff, radix_in;
   logic [2:0]            suffix_ff, suffix_in;
   logic                  rerr_ff, rerr_in;
   logic                  ovf_ff, ovf_in;
   logic                  any_ff, any_in;

   logic [7:0] c;
   logic       is_dec, is_hex_letter, is_digit, is_under;
   logic       is_x, is_b, is_u, is_l;
   logic [3:0] digit_raw;
   logic [3:0] digit;
   logic       out_of_range;
   logic [PW-1:0] acc_ext, scaled;
   logic       too_big;
   logic       go_digits, go_suffix, done, consumed;

   assign c             = item.char_code;
   assign is_dec        = c inside {[CH_ZERO:CH_NINE]};
   assign is_hex_letter = c inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
   assign is_digit      = is_dec || is_hex_letter;
   assign is_under      = (c == CH_UNDER);
   assign is_x          = c inside {CH_LO_X, CH_UP_X};
   assign is_b          = c inside {CH_LO_B, CH_UP_B};
   assign is_u          = c inside {CH_LO_U, CH_UP_U};
   assign is_l          = c inside {CH_LO_L, CH_UP_L};
   // letters a-f and A-F have low nibbles 1..6
   assign digit_raw     = is_dec ? c[3:0] : c[3:0] + 4'd9;

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      radix_in     = radix_ff;
      suffix_in    = suffix_ff;
      rerr_in      = rerr_ff;
      ovf_in       = ovf_ff;
      any_in       = any_ff;
      go_digits    = 1'b0;
      go_suffix    = 1'b0;
      done         = 1'b0;
      consumed     = 1'b0;
      out_of_range = 1'b0;
      digit        = digit_raw;
      acc_ext      = '0;
      scaled       = '0;
      too_big      = 1'b0;

      if (item.starts_literal) begin
         acc_in    = '0;
         radix_in  = RADIX_DEC;
         suffix_in = SFX_NONE;
         rerr_in   = 1'b0;
         ovf_in    = 1'b0;
         any_in    = 1'b0;
         if (c == CH_ZERO) begin
            phase_in = PH_ZERO;
         end else begin
            go_digits = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_ZERO: begin
               if (is_x) begin
                  radix_in = RADIX_HEX;
                  phase_in = PH_DIGITS;
               end else if (is_b) begin
                  radix_in = RADIX_BIN;
                  phase_in = PH_DIGITS;
               end else begin
                  radix_in  = is_dec ? RADIX_OCT : RADIX_DEC;
                  go_digits = 1'b1;
               end
            end
            PH_DIGITS: begin
               go_digits = 1'b1;
            end
            PH_OVF_SKIP: begin
               if (!(is_dec || is_under)) begin
                  go_suffix = 1'b1;
               end
            end
            PH_SUF_START: begin
               go_suffix = 1'b1;
            end
            PH_SUF_U: begin
               if (is_l) begin
                  suffix_in = SFX_UL;
                  phase_in  = PH_SUF_UL;
               end else begin
                  done = 1'b1;
               end
            end
            PH_SUF_UL: begin
               done = 1'b1;
               if (is_l) begin
                  suffix_in = SFX_ULL;
                  consumed  = 1'b1;
               end
            end
            PH_SUF_L: begin
               done = 1'b1;
               if (is_l) begin
                  suffix_in = SFX_LL;
                  consumed  = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (go_digits) begin
         phase_in = PH_DIGITS;
         if (is_under) begin
            any_in = 1'b1;
         end else if (!is_digit) begin
            go_suffix = 1'b1;
         end else begin
            case (radix_in)
               RADIX_DEC: out_of_range = (digit_raw > 4'd9);
               RADIX_BIN: out_of_range = (digit_raw > 4'd1);
               RADIX_OCT: out_of_range = (digit_raw > 4'd7);
               default:   out_of_range = 1'b0;
            endcase
            if (out_of_range) begin
               rerr_in = 1'b1;
               digit   = 4'd0;
            end
            acc_ext = {4'd0, acc_in};
            case (radix_in)
               RADIX_DEC: scaled = (acc_ext << 3) + (acc_ext << 1) + PW'(digit);
               RADIX_HEX: scaled = (acc_ext << 4) + PW'(digit);
               RADIX_BIN: scaled = (acc_ext << 1) + PW'(digit);
               default:   scaled = (acc_ext << 3) + PW'(digit);
            endcase
            too_big = |scaled[PW-1:VALUE_BITS];
            if (too_big) begin
               ovf_in = 1'b1;
               acc_in = '0;
               // a hex letter cannot be swallowed, it closes the digits
               if (is_dec) begin
                  phase_in = PH_OVF_SKIP;
               end else begin
                  go_suffix = 1'b1;
               end
            end else begin
               acc_in = scaled[VALUE_BITS-1:0];
               any_in = 1'b1;
            end
         end
      end

      if (go_suffix) begin
         if (is_u) begin
            suffix_in = SFX_U;
            phase_in  = PH_SUF_U;
         end else if (is_l) begin
            suffix_in = SFX_L;
            phase_in  = PH_SUF_L;
         end else begin
            done = 1'b1;
         end
      end

      if (done) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         acc_ff    <= '0;
         radix_ff  <= RADIX_DEC;
         suffix_ff <= SFX_NONE;
         rerr_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         any_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         radix_ff  <= radix_in;
         suffix_ff <= suffix_in;
         rerr_ff   <= rerr_in;
         ovf_ff    <= ovf_in;
         any_ff    <= any_in;
      end
   end

   assign emit  = done;
   assign value = acc_in;

   always_comb begin
      flags.radix_kind          = radix_in;
      flags.suffix_kind         = suffix_in;
      flags.digit_range_error   = rerr_in;
      flags.overflow_error      = ovf_in;
      flags.no_digits_error     = (radix_in == RADIX_HEX || radix_in == RADIX_BIN) && !any_in;
      flags.final_char_consumed = consumed;
   end

endmodule

/* rtl/ils_result_reg.sv */
// ----------------------------------------------------------------------------
// ils_result_reg
// Result register driving the token channel.
// ----------------------------------------------------------------------------
module ils_result_reg #(
   parameter int unsigned VALUE_BITS = ils_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [VALUE_BITS-1:0]  value,
   input  ils_pkg::ils_flags_type flags,
   output logic                   slot_free,
   ils_rsp_if.source              rsp_chan
);
   import ils_pkg::*;

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff;
   ils_flags_type         flags_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value;
         flags_ff <= flags;
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.literal_value       = value_ff;
   assign rsp_chan.radix_kind          = flags_ff.radix_kind;
   assign rsp_chan.suffix_kind         = flags_ff.suffix_kind;
   assign rsp_chan.digit_range_error   = flags_ff.digit_range_error;
   assign rsp_chan.overflow_error      = flags_ff.overflow_error;
   assign rsp_chan.no_digits_error     = flags_ff.no_digits_error;
   assign rsp_chan.final_char_consumed = flags_ff.final_char_consumed;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives integer literal characters into the scanner and checks every token
// against a cycle-free model of the scan, first from a short script of
// characters, then from random literals and noise under varying back pressure.
// ----------------------------------------------------------------------------
module testbench;
   import ils_pkg::*;

   localparam int unsigned VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam logic [VALUE_BITS-1:0] VALUE_CEILING = '1;

   // characters the scan cares about
   localparam logic [7:0] CH_0          = "0";
   localparam logic [7:0] CH_1          = "1";
   localparam logic [7:0] CH_7          = "7";
   localparam logic [7:0] CH_9          = "9";
   localparam logic [7:0] CH_LOW_A      = "a";
   localparam logic [7:0] CH_LOW_F      = "f";
   localparam logic [7:0] CH_UP_A       = "A";
   localparam logic [7:0] CH_UP_F       = "F";
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_X          = "x";
   localparam logic [7:0] CH_B          = "b";
   localparam logic [7:0] CH_U          = "u";
   localparam logic [7:0] CH_L          = "l";
   localparam logic [7:0] CASE_DISTANCE = 8'd32;
   localparam logic [4:0] NOT_A_DIGIT   = 5'd16;

   localparam int DRAIN_CYCLES    = 8;
   localparam int CHARS_PER_PHASE = 200;

   // scan states of the model
   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_ZERO,
      SCAN_DIGITS,
      SCAN_OVF_SKIP,
      SCAN_SUF_U,
      SCAN_SUF_UL,
      SCAN_SUF_L,
      SCAN_SUF_START
   } scan_state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      ils_flags_type         flags;
   } token_type;

   // one row of the directed script; a typed token replaces the model's
   typedef struct {
      logic [7:0] ch;
      logic       start;
      bit         typed;
      token_type  want;
   } script_row_type;

   logic clock;
   logic reset;

   ils_req_if                              req_chan ();
   ils_rsp_if #(.VALUE_BITS(VALUE_BITS))   rsp_chan ();

   integer_literal_scanner #(
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // model state, a copy of what the scanner holds for the running token
   scan_state_type        scan_phase;
   logic [VALUE_BITS-1:0] run_value;
   logic [1:0]            run_radix;
   logic [2:0]            run_suffix;
   logic                  run_range_err;
   logic                  run_overflow;
   logic                  run_body_seen;

   token_type      pending_tokens[$];   // tokens still owed by the scanner
   script_row_type script_rows[$];
   int          mismatch_count = 0;
   int          scanned_chars  = 0;  // characters that were not simply ignored
   int          gap_pct        = 0;  // sender idle chance per cycle
   int          stall_pct      = 0;  // receiver stall chance per cycle
   int          gap_by_phase[4]   = '{0, 46, 0, 28};
   int          stall_by_phase[4] = '{0, 0, 46, 28};

   // ------------------------------------------------------------------------
   // clock, and a hard stop in case the scanner hangs
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(6_000_000);
      $display("[integer_literal_scanner] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // character helpers
   // ------------------------------------------------------------------------
   function automatic logic [4:0] digit_of(input logic [7:0] ch);
      if (ch >= CH_0 && ch <= CH_9) return 5'(ch - CH_0);
      if (ch >= CH_LOW_A && ch <= CH_LOW_F) return 5'(ch - CH_LOW_A + 8'd10);
      if (ch >= CH_UP_A && ch <= CH_UP_F) return 5'(ch - CH_UP_A + 8'd10);
      return NOT_A_DIGIT;
   endfunction

   function automatic bit is_letter(input logic [7:0] ch, input logic [7:0] lower);
      return ch == lower || ch == lower - CASE_DISTANCE;
   endfunction

   function automatic bit is_dec(input logic [7:0] ch);
      return ch >= CH_0 && ch <= CH_9;
   endfunction

   function automatic logic [VALUE_BITS-1:0] base_of(input logic [1:0] radix);
      case (radix)
         RADIX_DEC: return VALUE_BITS'(10);
         RADIX_HEX: return VALUE_BITS'(16);
         RADIX_BIN: return VALUE_BITS'(2);
         default:   return VALUE_BITS'(8);
      endcase
   endfunction

   // lower case letter, flipped to upper case half the time
   function automatic logic [7:0] any_case(input logic [7:0] lower);
      return $urandom_range(0, 1) ? lower - CASE_DISTANCE : lower;
   endfunction

   function automatic token_type make_token(input logic [VALUE_BITS-1:0] value,
                                            input logic [1:0] radix,
                                            input logic [2:0] suffix,
                                            input logic range_err, input logic overflow,
                                            input logic no_digits, input logic consumed);
      token_type tok;
      tok.value                     = value;
      tok.flags.radix_kind          = radix;
      tok.flags.suffix_kind         = suffix;
      tok.flags.digit_range_error   = range_err;
      tok.flags.overflow_error      = overflow;
      tok.flags.no_digits_error     = no_digits;
      tok.flags.final_char_consumed = consumed;
      return tok;
   endfunction

   // ------------------------------------------------------------------------
   // scan model: one character in, at most one finished token out
   // ------------------------------------------------------------------------
   task automatic predict_step(input logic [7:0] ch, input logic start,
                               output bit produced, output token_type tok);
      logic [4:0]            dv;
      logic [VALUE_BITS-1:0] base;
      logic [VALUE_BITS-1:0] d;
      bit                    more;
      bit                    ends;
      bit                    eaten;
      produced = 1'b0;
      tok      = '0;
      ends     = 1'b0;
      eaten    = 1'b0;
      if (start) begin
         // a start always opens a fresh token, dropping any unfinished one
         run_value     = '0;
         run_radix     = RADIX_DEC;
         run_suffix    = SFX_NONE;
         run_range_err = 1'b0;
         run_overflow  = 1'b0;
         run_body_seen = 1'b0;
         if (ch == CH_0) begin
            scan_phase = SCAN_ZERO;
            return;
         end
         scan_phase = SCAN_DIGITS;
      end else if (scan_phase == SCAN_IDLE) begin
         // stray character between tokens
         return;
      end
      // a state that does not take the character hands it to the next one
      more = 1'b1;
      while (more) begin
         more = 1'b0;
         case (scan_phase)
            SCAN_ZERO: begin
               scan_phase = SCAN_DIGITS;
               if (is_letter(ch, CH_X)) begin
                  run_radix = RADIX_HEX;
               end else if (is_letter(ch, CH_B)) begin
                  run_radix = RADIX_BIN;
               end else begin
                  run_radix = is_dec(ch) ? RADIX_OCT : RADIX_DEC;
                  more      = 1'b1;
               end
            end
            SCAN_DIGITS: begin
               dv = digit_of(ch);
               if (ch == CH_UNDERSCORE) begin
                  run_body_seen = 1'b1;
               end else if (dv == NOT_A_DIGIT) begin
                  scan_phase = SCAN_SUF_START;
                  more       = 1'b1;
               end else begin
                  base = base_of(run_radix);
                  d    = VALUE_BITS'(dv);
                  // digit too big for the radix counts as zero
                  if (d >= base) begin
                     run_range_err = 1'b1;
                     d             = '0;
                  end
                  if (run_value > (VALUE_CEILING - d) / base) begin
                     run_overflow = 1'b1;
                     run_value    = '0;
                     scan_phase   = SCAN_OVF_SKIP;
                     more         = 1'b1;
                  end else begin
                     run_value     = run_value * base + d;
                     run_body_seen = 1'b1;
                  end
               end
            end
            SCAN_OVF_SKIP: begin
               // after overflow only decimal digits and underscores are swallowed
               if (!(is_dec(ch) || ch == CH_UNDERSCORE)) begin
                  scan_phase = SCAN_SUF_START;
                  more       = 1'b1;
               end
            end
            SCAN_SUF_START: begin
               if (is_letter(ch, CH_U)) begin
                  run_suffix = SFX_U;
                  scan_phase = SCAN_SUF_U;
               end else if (is_letter(ch, CH_L)) begin
                  run_suffix = SFX_L;
                  scan_phase = SCAN_SUF_L;
               end else begin
                  ends = 1'b1;
               end
            end
            SCAN_SUF_U: begin
               if (is_letter(ch, CH_L)) begin
                  run_suffix = SFX_UL;
                  scan_phase = SCAN_SUF_UL;
               end else begin
                  ends = 1'b1;
               end
            end
            SCAN_SUF_UL: begin
               ends = 1'b1;
               if (is_letter(ch, CH_L)) begin
                  run_suffix = SFX_ULL;
                  eaten      = 1'b1;
               end
            end
            SCAN_SUF_L: begin
               ends = 1'b1;
               if (is_letter(ch, CH_L)) begin
                  run_suffix = SFX_LL;
                  eaten      = 1'b1;
               end
            end
            default: begin
               scan_phase = SCAN_IDLE;
            end
         endcase
      end
      if (ends) begin
         tok = make_token(run_value, run_radix, run_suffix, run_range_err, run_overflow,
                          (run_radix == RADIX_HEX || run_radix == RADIX_BIN) && !run_body_seen,
                          eaten);
         scan_phase = SCAN_IDLE;
         produced   = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // character sender: drives at the falling edge, transaction taken at the
   // rising edge with valid and ready high; the model runs on acceptance
   // ------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] ch, input logic start,
                            input bit typed, input token_type typed_tok);
      bit        produced;
      token_type tok;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.char_code      <= ch;
      req_chan.starts_literal <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (start || scan_phase != SCAN_IDLE) scanned_chars++;
      predict_step(ch, start, produced, tok);
      if (typed) pending_tokens.push_back(typed_tok);
      else if (produced) pending_tokens.push_back(tok);
   endtask

   // sender goes quiet until every owed token has come back
   task automatic drain_tokens();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   // one body character: mostly legal digits, some underscores and stray hex
   function automatic logic [7:0] body_char(input logic [1:0] radix);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 8) return CH_UNDERSCORE;
      if (r < 16) v = $urandom_range(0, 15);
      else v = $urandom_range(0, int'(base_of(radix)) - 1);
      return (v < 10) ? 8'(CH_0 + v) : any_case(8'(CH_LOW_A + v - 10));
   endfunction

   // ------------------------------------------------------------------------
   // random literal: prefix, body, suffix and terminator, or a noise burst
   // ------------------------------------------------------------------------
   task automatic emit_literal();
      logic [7:0] lit[$];
      logic [1:0] radix;
      int         kind;
      int         ndig;
      int         r;
      string      ceiling_text;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         // noise, including stray characters between tokens
         repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
         return;
      end
      if (kind < 5) begin
         // values at and just past the 64-bit ceiling
         case ($urandom_range(0, 5))
            0: begin
               ceiling_text = "18446744073709551615";
               for (int i = 0; i < ceiling_text.len(); i++) lit.push_back(ceiling_text[i]);
            end
            1: begin
               ceiling_text = "18446744073709551616";
               for (int i = 0; i < ceiling_text.len(); i++) lit.push_back(ceiling_text[i]);
            end
            2: begin
               lit.push_back(CH_0);
               lit.push_back(any_case(CH_X));
               repeat (16) lit.push_back(any_case(CH_LOW_F));
            end
            3: begin
               lit.push_back(CH_0);
               lit.push_back(any_case(CH_B));
               repeat (64) lit.push_back(CH_1);
            end
            4: begin
               lit.push_back(CH_0);
               lit.push_back(CH_1);
               repeat (21) lit.push_back(CH_7);
            end
            default: begin
               lit.push_back(CH_0);
               lit.push_back(any_case(CH_X));
               lit.push_back(CH_1);
               repeat (16) lit.push_back(CH_0);
               lit.push_back(any_case(CH_LOW_A));
            end
         endcase
      end else if (kind == 5) begin
         // start on an arbitrary character
         lit.push_back(8'($urandom_range(0, 255)));
      end else begin
         radix = 2'($urandom_range(0, 3));
         case (radix)
            RADIX_DEC: lit.push_back(8'(CH_1 + $urandom_range(0, 8)));
            RADIX_HEX: begin
               lit.push_back(CH_0);
               lit.push_back(any_case(CH_X));
            end
            RADIX_BIN: begin
               lit.push_back(CH_0);
               lit.push_back(any_case(CH_B));
            end
            default: begin
               lit.push_back(CH_0);
               lit.push_back(8'(CH_0 + $urandom_range(0, 7)));
            end
         endcase
         // mostly short bodies, now and then long enough to overflow
         if ($urandom_range(0, 99) < 85) ndig = $urandom_range(0, 6);
         else if (radix == RADIX_BIN) ndig = $urandom_range(60, 70);
         else ndig = $urandom_range(14, 24);
         repeat (ndig) lit.push_back(body_char(radix));
      end
      case ($urandom_range(0, 7))
         1: lit.push_back(any_case(CH_U));
         2: begin
            lit.push_back(any_case(CH_U));
            lit.push_back(any_case(CH_L));
         end
         3: begin
            lit.push_back(any_case(CH_U));
            lit.push_back(any_case(CH_L));
            lit.push_back(any_case(CH_L));
         end
         4: lit.push_back(any_case(CH_L));
         5: begin
            lit.push_back(any_case(CH_L));
            lit.push_back(any_case(CH_L));
         end
         6: begin
            lit.push_back(any_case(CH_L));
            lit.push_back(any_case(CH_U));
         end
         default: ;
      endcase
      // terminator: a separator, any byte, or none so the next start drops it
      r = $urandom_range(0, 99);
      if (r < 70) begin
         case ($urandom_range(0, 5))
            0: lit.push_back(" ");
            1: lit.push_back(";");
            2: lit.push_back(",");
            3: lit.push_back(")");
            4: lit.push_back(8'h0A);
            default: lit.push_back(8'($urandom_range(128, 255)));
         endcase
      end else if (r < 90) begin
         lit.push_back(8'($urandom_range(0, 255)));
      end
      foreach (lit[i]) send_char(lit[i], i == 0, 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // result side: ready moves at the falling edge, tokens checked at the
   // rising edge in arrival order
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : token_monitor
      token_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_tokens.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected token, expected none, actual value %0h",
                     $time, rsp_chan.literal_value);
         end else begin
            want = pending_tokens.pop_front();
            compare_field("literal_value", 64'(want.value), 64'(rsp_chan.literal_value));
            compare_field("radix_kind", 64'(want.flags.radix_kind),
                          64'(rsp_chan.radix_kind));
            compare_field("suffix_kind", 64'(want.flags.suffix_kind),
                          64'(rsp_chan.suffix_kind));
            compare_field("digit_range_error", 64'(want.flags.digit_range_error),
                          64'(rsp_chan.digit_range_error));
            compare_field("overflow_error", 64'(want.flags.overflow_error),
                          64'(rsp_chan.overflow_error));
            compare_field("no_digits_error", 64'(want.flags.no_digits_error),
                          64'(rsp_chan.no_digits_error));
            compare_field("final_char_consumed", 64'(want.flags.final_char_consumed),
                          64'(rsp_chan.final_char_consumed));
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid          = 1'b0;
      req_chan.char_code      = 8'h00;
      req_chan.starts_literal = 1'b0;
      rsp_chan.ready          = 1'b0;
      reset                   = 1'b1;
      scan_phase              = SCAN_IDLE;
      run_value               = '0;
      run_radix               = RADIX_DEC;
      run_suffix              = SFX_NONE;
      run_range_err           = 1'b0;
      run_overflow            = 1'b0;
      run_body_seen           = 1'b0;

      // directed script; tokens are typed in where they are plain to see
      script_rows = '{
         '{"A",   1'b0, 1'b0, '0},  // stray character while idle, ignored
         '{"0",   1'b1, 1'b0, '0},
         '{"x",   1'b0, 1'b0, '0},
         // hex prefix with nothing after it, ended by the top byte value
         '{8'hFF, 1'b0, 1'b1,
           make_token('0, RADIX_HEX, SFX_NONE, 1'b0, 1'b0, 1'b1, 1'b0)},
         '{"0",   1'b1, 1'b0, '0},
         '{"B",   1'b0, 1'b0, '0},
         '{"2",   1'b0, 1'b0, '0},  // out of range for binary, counts as zero
         '{"1",   1'b0, 1'b0, '0},
         '{"L",   1'b0, 1'b0, '0},
         '{"l",   1'b0, 1'b1,
           make_token(VALUE_BITS'(1), RADIX_BIN, SFX_LL, 1'b1, 1'b0, 1'b0, 1'b1)},
         '{"9",   1'b1, 1'b0, '0},
         '{"U",   1'b0, 1'b0, '0},
         '{"l",   1'b0, 1'b0, '0},
         '{"L",   1'b0, 1'b1,
           make_token(VALUE_BITS'(9), RADIX_DEC, SFX_ULL, 1'b0, 1'b0, 1'b0, 1'b1)},
         // start on a suffix letter, ended by the zero byte
         '{"u",   1'b1, 1'b0, '0},
         '{8'h00, 1'b0, 1'b1,
           make_token('0, RADIX_DEC, SFX_U, 1'b0, 1'b0, 1'b0, 1'b0)},
         '{"0",   1'b1, 1'b0, '0},
         '{"7",   1'b0, 1'b0, '0},
         '{"_",   1'b0, 1'b0, '0},
         '{"8",   1'b0, 1'b0, '0},  // out of range for octal
         '{"l",   1'b0, 1'b0, '0},
         '{"x",   1'b0, 1'b1,
           make_token(VALUE_BITS'(56), RADIX_OCT, SFX_L, 1'b1, 1'b0, 1'b0, 1'b0)},
         '{"5",   1'b1, 1'b0, '0},
         '{"0",   1'b1, 1'b0, '0},  // new start drops the unfinished token
         // zero followed by another character stays decimal
         '{"g",   1'b0, 1'b1,
           make_token('0, RADIX_DEC, SFX_NONE, 1'b0, 1'b0, 1'b0, 1'b0)}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         send_char(script_rows[i].ch, script_rows[i].start, script_rows[i].typed,
                   script_rows[i].want);
      drain_tokens();

      // random literals in four pacing phases, drained between phases
      for (int p = 0; p < 4; p++) begin
         gap_pct   = gap_by_phase[p];
         stall_pct = stall_by_phase[p];
         while (scanned_chars < (p + 1) * CHARS_PER_PHASE) emit_literal();
         drain_tokens();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[integer_literal_scanner] OK");
      end else begin
         $display("[integer_literal_scanner] ERROR");
      end
      $finish;
   end

endmodule
